// File: design/bsp_pkg.sv
// bsp_pkg: shared widths, codes, walk states and the side-test result type
// for the BSP point-location block. No dependencies.
package bsp_pkg;

  localparam int FIELD_W  = 32;
  localparam int IDX_W    = 12;
  localparam int CHILD_W  = 13;
  localparam int COUNT_W  = 13;
  localparam int LEAF_BIT = 12;

  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  localparam logic SIDE_FRONT = 1'b0;
  localparam logic SIDE_BACK  = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_WAIT
  } walk_state_t;

  typedef struct packed {
    logic done;
    logic side;
  } side_res_t;

endpackage

// File: design/bsp_in_if.sv
// bsp_in_if: input request channel (load or query) with valid/ready.
// Depends on bsp_pkg.
interface bsp_in_if import bsp_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      action;
  logic        [IDX_W-1:0]   node_index;
  logic signed [FIELD_W-1:0] part_x;
  logic signed [FIELD_W-1:0] part_y;
  logic signed [FIELD_W-1:0] part_dx;
  logic signed [FIELD_W-1:0] part_dy;
  logic                      front_is_leaf;
  logic        [IDX_W-1:0]   front_child;
  logic                      back_is_leaf;
  logic        [IDX_W-1:0]   back_child;
  logic signed [FIELD_W-1:0] point_x;
  logic signed [FIELD_W-1:0] point_y;

  modport source (
    output valid, action, node_index, part_x, part_y, part_dx, part_dy,
           front_is_leaf, front_child, back_is_leaf, back_child, point_x, point_y,
    input  ready
  );
  modport sink (
    input  valid, action, node_index, part_x, part_y, part_dx, part_dy,
           front_is_leaf, front_child, back_is_leaf, back_child, point_x, point_y,
    output ready
  );
endinterface

// File: design/bsp_out_if.sv
// bsp_out_if: result channel (leaf index and walk error) with valid/ready.
// Depends on bsp_pkg.
interface bsp_out_if import bsp_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] leaf_index;
  logic             walk_error;

  modport source (output valid, leaf_index, walk_error, input ready);
  modport sink   (input valid, leaf_index, walk_error, output ready);
endinterface

// File: design/bsp_ram.sv
// bsp_ram: generic single-port synchronous RAM, registered read data.
// No dependencies.
module bsp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic             re,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: design/bsp_side_unit.sv
// bsp_side_unit: side-of-partition test. Stage 1 does axis and quadrant
// decisions, stage 2 the two cross products; compare at the output. Uses bsp_pkg.
module bsp_side_unit import bsp_pkg::*; #(
  parameter int CB = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic signed [CB-1:0] x,
  input  logic signed [CB-1:0] y,
  input  logic signed [CB-1:0] px,
  input  logic signed [CB-1:0] py,
  input  logic signed [CB-1:0] pdx,
  input  logic signed [CB-1:0] pdy,
  output side_res_t            res
);

  logic signed [CB:0]   dx_w, dy_w;
  logic                 dec1_nxt, side1_nxt;
  logic                 nx, ny, sx, sy;

  logic                 v1_r, v2_r;
  logic                 dec1_r, side1_r;
  logic signed [CB:0]   dx_r, dy_r;
  logic signed [CB-1:0] pdx_r, pdy_r;
  logic signed [2*CB:0] pa_r, pb_r;

  always_comb begin
    dx_w = $signed({x[CB-1], x}) - $signed({px[CB-1], px});
    dy_w = $signed({y[CB-1], y}) - $signed({py[CB-1], py});
    nx = pdx[CB-1];
    ny = pdy[CB-1];
    sx = dx_w[CB];
    sy = dy_w[CB];
    dec1_nxt  = 1'b1;
    side1_nxt = SIDE_FRONT;
    if (pdx == '0) begin
      if (x <= px) side1_nxt = (pdy > 0) ? SIDE_BACK : SIDE_FRONT;
      else         side1_nxt = (pdy < 0) ? SIDE_BACK : SIDE_FRONT;
    end else if (pdy == '0) begin
      if (y <= py) side1_nxt = (pdx < 0) ? SIDE_BACK : SIDE_FRONT;
      else         side1_nxt = (pdx > 0) ? SIDE_BACK : SIDE_FRONT;
    end else begin
      unique case ({nx, ny})
        2'b11: begin
          if (sx && !sy)      side1_nxt = SIDE_FRONT;
          else if (!sx && sy) side1_nxt = SIDE_BACK;
          else                dec1_nxt  = 1'b0;
        end
        2'b10: begin
          if (sx && sy)        side1_nxt = SIDE_BACK;
          else if (!sx && !sy) side1_nxt = SIDE_FRONT;
          else                 dec1_nxt  = 1'b0;
        end
        2'b01: begin
          if (sx && sy)        side1_nxt = SIDE_FRONT;
          else if (!sx && !sy) side1_nxt = SIDE_BACK;
          else                 dec1_nxt  = 1'b0;
        end
        default: begin
          if (sx && !sy)      side1_nxt = SIDE_BACK;
          else if (!sx && sy) side1_nxt = SIDE_FRONT;
          else                dec1_nxt  = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= start;
      v2_r <= v1_r && !dec1_r;
    end
  end

  always_ff @(posedge clk) begin
    dec1_r  <= dec1_nxt;
    side1_r <= side1_nxt;
    dx_r    <= dx_w;
    dy_r    <= dy_w;
    pdx_r   <= pdx;
    pdy_r   <= pdy;
    pa_r    <= dy_r * pdx_r;
    pb_r    <= pdy_r * dx_r;
  end

  // cross product: front when dy*pdx < pdy*dx
  assign res.done = (v1_r && dec1_r) || v2_r;
  assign res.side = v2_r ? ((pa_r < pb_r) ? SIDE_FRONT : SIDE_BACK) : side1_r;

endmodule

// File: design/bsp_point_locate_core.sv
// bsp_point_locate_core: BSP node table in one RAM plus the walk sequencer.
// Depends on bsp_pkg, bsp_in_if, bsp_out_if, bsp_ram, bsp_side_unit.
//
//  channel  | direction | request contents
//  ---------+-----------+-------------------------------------------------
//  in_req   | in        | load one node entry, or query one point
//  out_rsp  | out       | leaf_index, walk_error (one per query)
//  cfg      | in        | node_count write (cfg_we, cfg_wdata)
//
// A load writes its node entry as it is accepted. A query visits nodes in turn: per
// node, the RAM read, then the stage-1 register when the axis or quadrant test
// decides, and the multiply register as well when the cross product does.
// Reset is synchronous; the node table is not cleared and needs no sweep.
// in_req is taken only between queries; a finished result waits in the
// output register, and the walk holds at its last step while that is full.
module bsp_point_locate_core import bsp_pkg::*; #(
  parameter int MAX_NODES  = 4096,
  parameter int COORD_BITS = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  bsp_in_if.sink             in_req,
  bsp_out_if.source          out_rsp,
  input  logic               cfg_we,
  input  logic [COUNT_W-1:0] cfg_wdata
);

  localparam int CB        = COORD_BITS;
  localparam int TBL_DEPTH = (MAX_NODES < (1 << IDX_W)) ? MAX_NODES : (1 << IDX_W);
  localparam int AW        = $clog2(TBL_DEPTH);
  localparam int ENT_W     = 4 * CB + 2 * CHILD_W;
  localparam int CAP_I     = (MAX_NODES < (1 << COUNT_W) - 1) ? MAX_NODES
                                                               : (1 << COUNT_W) - 1;
  localparam logic [COUNT_W-1:0] CNT_CAP = COUNT_W'(CAP_I);

  walk_state_t          state_r, state_nxt;
  logic [COUNT_W-1:0]   node_count_r;
  logic [COUNT_W-1:0]   count_r, count_nxt, count_clamp;
  logic [COUNT_W-1:0]   steps_r, steps_nxt;
  logic [CHILD_W-1:0]   child_r, child_nxt;
  logic signed [CB-1:0] x_r, y_r;
  logic                 zero_r, zero_nxt;
  logic                 rd_pend_r;
  logic                 out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0]     out_leaf_r, res_leaf;
  logic                 out_err_r, res_err;

  logic                 in_acc, in_ready, load_we, rd_issue, res_now, out_load;
  logic [IDX_W-1:0]     node_idx;
  logic [AW-1:0]        ram_addr;
  logic [ENT_W-1:0]     ram_wdata, ram_rdata, entry;
  logic [CHILD_W-1:0]   front_ch, back_ch;
  logic signed [CB-1:0] e_px, e_py, e_pdx, e_pdy;
  side_res_t            side_res;

  assign in_acc   = in_req.valid && in_ready;
  assign node_idx = child_r[IDX_W-1:0];
  assign load_we  = in_acc && (in_req.action == ACT_LOAD) &&
                    (32'(in_req.node_index) < MAX_NODES);
  assign ram_addr = (state_r == ST_IDLE) ? in_req.node_index[AW-1:0] : node_idx[AW-1:0];
  assign ram_wdata = {in_req.back_is_leaf, in_req.back_child,
                      in_req.front_is_leaf, in_req.front_child,
                      in_req.part_dy[CB-1:0], in_req.part_dx[CB-1:0],
                      in_req.part_y[CB-1:0], in_req.part_x[CB-1:0]};

  bsp_ram #(
    .WIDTH (ENT_W),
    .DEPTH (TBL_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (load_we),
    .re    (rd_issue),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // nodes beyond the table read as an all-zero entry
  assign entry = zero_r ? '0 : ram_rdata;
  assign {back_ch, front_ch, e_pdy, e_pdx, e_py, e_px} = entry;

  bsp_side_unit #(
    .CB (CB)
  ) u_side (
    .clk   (clk),
    .rst_n (rst_n),
    .start (rd_pend_r),
    .x     (x_r),
    .y     (y_r),
    .px    (e_px),
    .py    (e_py),
    .pdx   (e_pdx),
    .pdy   (e_pdy),
    .res   (side_res)
  );

  assign count_clamp = (node_count_r > CNT_CAP) ? CNT_CAP : node_count_r;

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    steps_nxt = steps_r;
    child_nxt = child_r;
    zero_nxt  = zero_r;
    in_ready  = 1'b0;
    rd_issue  = 1'b0;
    res_now   = 1'b0;
    res_leaf  = '0;
    res_err   = 1'b0;
    out_load  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_acc && (in_req.action == ACT_QUERY)) begin
          count_nxt = count_clamp;
          steps_nxt = '0;
          child_nxt = count_clamp - COUNT_W'(1);
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        priority if (count_r == '0) begin
          res_now = 1'b1;
        end else if (child_r[LEAF_BIT]) begin
          res_now  = 1'b1;
          res_leaf = child_r[IDX_W-1:0];
        end else if (steps_r >= count_r) begin
          res_now = 1'b1;
          res_err = 1'b1;
        end else begin
          rd_issue  = 1'b1;
          zero_nxt  = !(32'(node_idx) < MAX_NODES);
          steps_nxt = steps_r + COUNT_W'(1);
          state_nxt = ST_WAIT;
        end
        if (res_now && (!out_valid_r || out_rsp.ready)) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_WAIT: begin
        if (side_res.done) begin
          child_nxt = (side_res.side == SIDE_BACK) ? back_ch : front_ch;
          state_nxt = ST_CHECK;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    out_valid_nxt = out_load ? 1'b1 : (out_valid_r && !out_rsp.ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      node_count_r <= '0;
      count_r      <= '0;
      steps_r      <= '0;
      child_r      <= '0;
      zero_r       <= 1'b0;
      rd_pend_r    <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      steps_r   <= steps_nxt;
      child_r   <= child_nxt;
      zero_r    <= zero_nxt;
      rd_pend_r <= rd_issue;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        node_count_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && (in_req.action == ACT_QUERY)) begin
      x_r <= in_req.point_x[CB-1:0];
      y_r <= in_req.point_y[CB-1:0];
    end
    if (out_load) begin
      out_leaf_r <= res_leaf;
      out_err_r  <= res_err;
    end
  end

  assign in_req.ready       = in_ready;
  assign out_rsp.valid      = out_valid_r;
  assign out_rsp.leaf_index = out_leaf_r;
  assign out_rsp.walk_error = out_err_r;

  a_side_only_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    side_res.done |-> state_r == ST_WAIT)
    else $error("side result outside of wait state");

  a_steps_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_WAIT |-> (steps_r != '0) && (steps_r <= count_r))
    else $error("walk step count out of range");

  a_load_stays_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_req.valid && in_req.ready && in_req.action == ACT_LOAD) |=> state_r == ST_IDLE)
    else $error("load request started a walk");

  a_read_then_test: assert property (@(posedge clk) disable iff (!rst_n)
    rd_pend_r |-> (state_r == ST_WAIT) && !side_res.done)
    else $error("table read data not consumed by side test");

endmodule
